[rtl/core/rcc_pkg.sv]
// Shared types and constants for the RTT-clustering congestion window controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package rcc_pkg;
	localparam int DEPTH     = 64;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int FRAC      = 8;
	localparam int RTT_W     = 16;
	localparam int WIN_W     = 24;
	localparam int ALPHA_W   = 17;
	localparam int CEN_W     = 24;
	localparam int SUM_W     = RTT_W + CNT_W;
	localparam int DIVD_W    = SUM_W + FRAC;
	localparam int ALPHA_ONE = 65536;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CWND    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CWND_MAX     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG_LEN  = 2'd3;

	typedef struct packed {
		logic [RTT_W-1:0] rtt_ms;
		logic             loss;
		logic [WIN_W-1:0] in_flight_bytes;
	} item_t;

	typedef struct packed {
		logic [WIN_W-1:0]   init_cwnd;
		logic [WIN_W-1:0]   cwnd_max;
		logic [ALPHA_W-1:0] alpha_thresh;
		logic [6:0]         backlog_len;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INSERT, ST_WALK, ST_DIV_START, ST_DIV_WAIT,
		ST_UPDATE, ST_MUL, ST_WIN, ST_DONE
	} state_t;
endpackage
`default_nettype wire

[rtl/core/rtt_cluster_cwnd_controller_top.sv]
// Top level of the RTT-clustering congestion window controller.
// Depends on rcc_pkg, rcc_front, rcc_back (which uses rcc_div).
//
// One ACK transaction in gives one result transaction out. A loss report goes
// straight to the window update, without a backlog write. Without loss, the
// sample is written to the backlog; once both centroids exist, there follows
// one pass over the backlog memory (up to 64 entries held) to label samples,
// then three serial divisions (two centroid means, the high share) on one
// bit-per-cycle divider. A two-entry queue takes new ACKs while the back end
// is busy, and the result register holds a finished result while the next
// ACK is processed. The backlog needs no clearing after reset. Configuration
// is written through cfg_valid/cfg_ready (always ready) with cfg_index 0..3 =
// init_cwnd, cwnd_max, alpha_thresh, backlog_len; write only while idle.
// init_cwnd sets the window floor; the window itself resets to 14600 bytes.
`default_nettype none
module rtt_cluster_cwnd_controller_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [15:0]                       rtt_ms,
	input  wire logic                              loss,
	input  wire logic [23:0]                       in_flight_bytes,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [23:0]                            cwnd_size,
	output logic [23:0]                            cwnd_free,
	output logic [16:0]                            alpha_q16,
	output logic [23:0]                            centroid_low,
	output logic [23:0]                            centroid_high,
	output logic [1:0]                             centroids_valid,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [23:0]                       cfg_data
);
	import rcc_pkg::*;

	cfg_t  cfg_q;
	item_t in_item, q_item;
	logic  q_valid, q_pop;

	assign cfg_ready = 1'b1;
	assign in_item   = '{rtt_ms: rtt_ms, loss: loss, in_flight_bytes: in_flight_bytes};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_cwnd    <= WIN_W'(14600);
			cfg_q.cwnd_max     <= WIN_W'(1048576);
			cfg_q.alpha_thresh <= ALPHA_W'(32768);
			cfg_q.backlog_len  <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_INIT_CWND:    cfg_q.init_cwnd    <= cfg_data;
				CFG_CWND_MAX:     cfg_q.cwnd_max     <= cfg_data;
				CFG_ALPHA_THRESH: cfg_q.alpha_thresh <= cfg_data[ALPHA_W-1:0];
				CFG_BACKLOG_LEN:  cfg_q.backlog_len  <= cfg_data[6:0];
				default:          ;
			endcase
		end
	end

	rcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	rcc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cwnd_size       (cwnd_size),
		.cwnd_free       (cwnd_free),
		.alpha_q16       (alpha_q16),
		.centroid_low    (centroid_low),
		.centroid_high   (centroid_high),
		.centroids_valid (centroids_valid)
	);

	// free bytes never exceed the window
	a_free_le_win: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cwnd_free <= cwnd_size) else $error("cwnd_free above cwnd_size");

	// alpha is a share, at most 1.0
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alpha_q16 <= 17'd65536) else $error("alpha above one");

	// a high centroid is reported only once both are established
	a_hi_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && centroids_valid != 2'd2) |-> centroid_high == 24'd0)
		else $error("high centroid before seeding");
endmodule
`default_nettype wire

[rtl/core/rcc_front.sv]
// Front end: accepts ACK transactions into a two-entry queue for the back end.
// Depends on rcc_pkg.
`default_nettype none
module rcc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire rcc_pkg::item_t in_item,
	output logic               q_valid,
	output rcc_pkg::item_t     q_item,
	input  wire logic          q_pop
);
	import rcc_pkg::*;

	item_t      buf_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop && q_valid) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end
endmodule
`default_nettype wire

[rtl/core/rcc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on rcc_pkg.
`default_nettype none
module rcc_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rcc_pkg::DIVD_W-1:0] dividend,
	input  wire logic [rcc_pkg::CNT_W-1:0]  divisor,
	output logic                            done,
	output logic [rcc_pkg::DIVD_W-1:0]      quotient
);
	import rcc_pkg::*;

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] num_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [CNT_W+1:0]  rem_sh;
	logic              fits;

	assign rem_sh   = {rem_q, num_q[DIVD_W-1]};
	assign fits     = rem_sh >= (CNT_W+2)'(den_q);
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVD_W-2:0], fits};
			rem_q <= fits ? (CNT_W+1)'(rem_sh - (CNT_W+2)'(den_q)) : rem_sh[CNT_W:0];
		end
	end
endmodule
`default_nettype wire

[rtl/core/rcc_back.sv]
// Back end: backlog memory, centroid seeding, clustering walk, divisions and
// window update, with the output register. Depends on rcc_pkg and rcc_div.
`default_nettype none
module rcc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rcc_pkg::cfg_t      cfg,
	input  wire logic               q_valid,
	input  wire rcc_pkg::item_t     q_item,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [23:0]             cwnd_size,
	output logic [23:0]             cwnd_free,
	output logic [16:0]             alpha_q16,
	output logic [23:0]             centroid_low,
	output logic [23:0]             centroid_high,
	output logic [1:0]              centroids_valid
);
	import rcc_pkg::*;

	localparam int SW = ADDR_W + 1;

	state_t state_q, state_d;
	item_t  item_q;

	logic [RTT_W-1:0]   mem [DEPTH];
	logic [RTT_W-1:0]   rd_data_q;
	logic               rd_vld_q;
	logic [ADDR_W-1:0]  head_q;
	logic [CNT_W-1:0]   fill_q, k_q;
	logic [WIN_W-1:0]   cwnd_q;
	logic [ALPHA_W-1:0] alpha_q, alpha_new_q;
	logic [CEN_W-1:0]   cen_lo_q, cen_hi_q, spread_q, a0_q, a1_q;
	logic [1:0]         ccount_q;
	logic [SUM_W-1:0]   sum_lo_q, sum_hi_q;
	logic [CNT_W-1:0]   n_lo_q, n_hi_q;
	logic [1:0]         div_sel_q;
	logic [41:0]        prod_q;
	logic               shrink_q;

	logic               pop, wr_en, div_start, issue, walk_end, load_out;
	logic [CNT_W-1:0]   lim, fill_next;
	logic [SW-1:0]      slot;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CEN_W-1:0]   x, xr, dlo, dhi, a0, a1, dspr;
	logic [27:0]        x10, lo11, lo9;
	logic               lab;
	logic [DIVD_W-1:0]  dividend, quotient;
	logic [CNT_W-1:0]   divisor;
	logic               div_done;
	logic [WIN_W:0]     shr;

	// clamp of the backlog length register
	always_comb begin
		if (cfg.backlog_len == 7'd0) begin
			lim = CNT_W'(1);
		end else if (CNT_W'(cfg.backlog_len) > CNT_W'(DEPTH)) begin
			lim = CNT_W'(DEPTH);
		end else begin
			lim = CNT_W'(cfg.backlog_len);
		end
		fill_next = (fill_q + 1'b1 > lim) ? lim : fill_q + 1'b1;
	end

	// entry k places before the newest
	always_comb begin
		slot = SW'(head_q) + SW'(DEPTH) - SW'(k_q) - SW'(1);
		if (slot >= SW'(DEPTH)) begin
			slot = slot - SW'(DEPTH);
		end
		rd_addr = slot[ADDR_W-1:0];
	end

	assign issue    = (state_q == ST_WALK) && (k_q < fill_q);
	assign walk_end = (state_q == ST_WALK) && !issue && !rd_vld_q;

	assign x    = CEN_W'({item_q.rtt_ms, FRAC'(0)});
	assign x10  = 28'(x) * 28'd10;
	assign lo11 = 28'(cen_lo_q) * 28'd11;
	assign lo9  = 28'(cen_lo_q) * 28'd9;

	assign xr  = CEN_W'({rd_data_q, FRAC'(0)});
	assign dlo = (xr > cen_lo_q) ? xr - cen_lo_q : cen_lo_q - xr;
	assign dhi = (xr > cen_hi_q) ? xr - cen_hi_q : cen_hi_q - xr;
	assign lab = !(dlo <= dhi);

	always_comb begin
		case (div_sel_q)
			2'd0: begin
				dividend = {sum_lo_q, FRAC'(0)};
				divisor  = n_lo_q;
			end
			2'd1: begin
				dividend = {sum_hi_q, FRAC'(0)};
				divisor  = n_hi_q;
			end
			default: begin
				dividend = DIVD_W'({n_hi_q, 16'd0});
				divisor  = fill_q;
			end
		endcase
	end

	rcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	assign a0   = (n_lo_q != '0) ? a0_q : cen_lo_q;
	assign a1   = (n_hi_q != '0) ? a1_q : cen_hi_q;
	assign dspr = (a0 > a1) ? a0 - a1 : a1 - a0;
	assign shr  = prod_q[41:17];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (q_valid) state_d = q_item.loss ? ST_MUL : ST_INSERT;
			ST_INSERT:    state_d = (ccount_q == 2'd2) ? ST_WALK : ST_MUL;
			ST_WALK:      if (walk_end) state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (div_sel_q == 2'd2) ? ST_UPDATE : ST_DIV_START;
				end
			end
			ST_UPDATE:    state_d = ST_MUL;
			ST_MUL:       state_d = ST_WIN;
			ST_WIN:       state_d = ST_DONE;
			ST_DONE:      if (!out_valid || !out_stall) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = 1'b0;
		wr_en     = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:      pop = q_valid;
			ST_INSERT:    wr_en = 1'b1;
			ST_DIV_START: div_start = 1'b1;
			ST_DONE:      load_out = !out_valid || !out_stall;
			default:      ;
		endcase
	end
	assign q_pop = pop;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= item_q.rtt_ms;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_INSERT) begin
			sum_lo_q <= '0;
			sum_hi_q <= '0;
			n_lo_q   <= '0;
			n_hi_q   <= '0;
			k_q      <= '0;
			div_sel_q <= 2'd0;
		end
		if (issue) begin
			k_q <= k_q + 1'b1;
		end
		if (rd_vld_q) begin
			if (lab) begin
				sum_hi_q <= sum_hi_q + SUM_W'(rd_data_q);
				n_hi_q   <= n_hi_q + 1'b1;
			end else begin
				sum_lo_q <= sum_lo_q + SUM_W'(rd_data_q);
				n_lo_q   <= n_lo_q + 1'b1;
			end
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			case (div_sel_q)
				2'd0:    a0_q <= CEN_W'(quotient);
				2'd1:    a1_q <= CEN_W'(quotient);
				default: alpha_new_q <= ALPHA_W'(quotient);
			endcase
			div_sel_q <= div_sel_q + 1'b1;
		end
		if (state_q == ST_MUL) begin
			prod_q   <= 42'(cwnd_q) * 42'(18'(2 * ALPHA_ONE) - 18'(alpha_q));
			shrink_q <= item_q.loss || (alpha_q > cfg.alpha_thresh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_vld_q <= 1'b0;
			head_q   <= '0;
			fill_q   <= '0;
			cwnd_q   <= WIN_W'(14600);
			alpha_q  <= ALPHA_W'(ALPHA_ONE / 2);
			cen_lo_q <= '0;
			cen_hi_q <= '0;
			spread_q <= '0;
			ccount_q <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= issue;
			if (state_q == ST_INSERT) begin
				head_q <= (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				fill_q <= fill_next;
				if (ccount_q == 2'd0) begin
					cen_lo_q <= x;
					ccount_q <= 2'd1;
				end else if (ccount_q == 2'd1) begin
					if (x10 > lo11) begin
						cen_hi_q <= x;
						ccount_q <= 2'd2;
					end else if (x10 < lo9) begin
						cen_hi_q <= cen_lo_q;
						cen_lo_q <= x;
						ccount_q <= 2'd2;
					end
				end
			end
			if (state_q == ST_UPDATE) begin
				if (spread_q < dspr) begin
					cen_lo_q <= a0;
					cen_hi_q <= a1;
					spread_q <= dspr;
				end
				alpha_q <= alpha_new_q;
			end
			if (state_q == ST_WIN) begin
				if (shrink_q) begin
					cwnd_q <= (shr < (WIN_W+1)'(cfg.init_cwnd)) ? cfg.init_cwnd : shr[WIN_W-1:0];
				end else if (cwnd_q < cfg.cwnd_max) begin
					cwnd_q <= cwnd_q + ((cfg.cwnd_max - cwnd_q) >> 1);
				end else begin
					cwnd_q <= cfg.cwnd_max;
				end
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cwnd_size       <= cwnd_q;
			cwnd_free       <= (cwnd_q > item_q.in_flight_bytes) ?
			                   cwnd_q - item_q.in_flight_bytes : '0;
			alpha_q16       <= alpha_q;
			centroid_low    <= (ccount_q >= 2'd1) ? cen_lo_q : '0;
			centroid_high   <= (ccount_q >= 2'd2) ? cen_hi_q : '0;
			centroids_valid <= ccount_q;
		end
	end
endmodule
`default_nettype wire
